// File: src/quad_corner_reorder_tracker_defines.svh
// Assertion macros for the quad corner reorder tracker.
`ifndef QUAD_CORNER_REORDER_TRACKER_DEFINES_SVH
`define QUAD_CORNER_REORDER_TRACKER_DEFINES_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset
`define QCRT_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("qcrt: property violated");
// Condition must never be seen outside reset
`define QCRT_NEVER(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("qcrt: forbidden condition seen");
`else
`define QCRT_ASSERT(label, prop)
`define QCRT_NEVER(label, expr)
`endif
`endif

// File: src/qcrt_pkg.sv
// Shared constants and types of the quad corner reorder tracker.
package qcrt_pkg;

	localparam int COORD_BITS_DEF    = 12;
	localparam int FRACTION_BITS_DEF = 4;
	localparam int NUM_CORNERS       = 4;
	localparam int SLOT_W            = 2;
	localparam int LIMIT_BITS        = 16;
	localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 16'd100;

	// Search radius: corners further away than this never match
	localparam int BOUND_DIST = 10000;
	localparam int BOUND_SQ   = BOUND_DIST * BOUND_DIST;
	localparam int BOUND_W    = $clog2(BOUND_DIST + 1);
	localparam int BSQ_W      = $clog2(BOUND_SQ + 1);

	typedef enum logic [2:0] {
		LANE_IDLE,
		LANE_DIST,
		LANE_CMP,
		LANE_ROOT,
		LANE_DONE
	} lane_state_t;

	// Lane status towards the merge stage
	typedef struct packed {
		logic                    done;
		logic [SLOT_W-1:0]       slot;
	} lane_stat_t;

endpackage

// File: src/qcrt_lane.sv
// One lane: nearest stored corner search and rounded distance for one new corner.
module qcrt_lane #(
	parameter int COORD_BITS    = qcrt_pkg::COORD_BITS_DEF,
	parameter int FRACTION_BITS = qcrt_pkg::FRACTION_BITS_DEF,
	localparam int D_W          = qcrt_pkg::BOUND_W + FRACTION_BITS
) (
	input  logic                                           clk,
	input  logic                                           arst_n,
	input  logic                                           start,
	input  logic                                           clear,
	input  logic [COORD_BITS-1:0]                          nx,
	input  logic [COORD_BITS-1:0]                          ny,
	input  logic [qcrt_pkg::NUM_CORNERS-1:0][COORD_BITS-1:0] px,
	input  logic [qcrt_pkg::NUM_CORNERS-1:0][COORD_BITS-1:0] py,
	output qcrt_pkg::lane_stat_t                           stat,
	output logic [D_W-1:0]                                 near_dist
);

	localparam int SQ_W    = 2 * COORD_BITS + 1;
	localparam int BSQ_W   = qcrt_pkg::BSQ_W;
	localparam int CMP_W   = (SQ_W > BSQ_W) ? SQ_W : BSQ_W;
	localparam int V_W     = BSQ_W + 2 * FRACTION_BITS;
	localparam int R_PAD   = ((V_W + 3) / 4) * 2;
	localparam int RAD_W   = 2 * R_PAD;
	localparam int REM_W   = R_PAD + 2;
	localparam int STEPS   = R_PAD / 2;
	localparam int STEP_W  = (STEPS > 1) ? $clog2(STEPS) : 1;
	localparam int SLOT_W  = qcrt_pkg::SLOT_W;
	localparam logic [D_W-1:0] FAR_DIST = D_W'(qcrt_pkg::BOUND_DIST * (2 ** FRACTION_BITS));
	localparam logic [BSQ_W-1:0] BOUND_SQ = BSQ_W'(qcrt_pkg::BOUND_SQ);

	qcrt_pkg::lane_state_t state_q, state_d;

	logic [SLOT_W-1:0]       j_q;
	logic [2*COORD_BITS-1:0] sqx_s1, sqy_s1;
	logic                    vld_s1;
	logic [SLOT_W-1:0]       idx_s1;
	logic [BSQ_W-1:0]        best_sq_q, best_sq_d;
	logic [SLOT_W-1:0]       best_q, best_d;
	logic                    found_q, found_d;
	logic [RAD_W-1:0]        rad_q;
	logic [REM_W-1:0]        rem_q;
	logic [R_PAD-1:0]        root_q;
	logic [STEP_W-1:0]       step_q;

	logic [COORD_BITS-1:0]   sel_x, sel_y, dx, dy;
	logic [SQ_W-1:0]         sq;
	logic                    better;
	logic [REM_W+1:0]        r1, r2, t1, t2;
	logic                    ge1, ge2;
	logic [REM_W-1:0]        rem1, rem2;
	logic [R_PAD-1:0]        root1, root2;
	logic [R_PAD:0]          rounded;

	// Distance issue: one stored corner per cycle
	always_comb begin
		sel_x = px[j_q];
		sel_y = py[j_q];
		dx    = (nx > sel_x) ? (nx - sel_x) : (sel_x - nx);
		dy    = (ny > sel_y) ? (ny - sel_y) : (sel_y - ny);
	end

	// Running minimum; strict compare keeps the lowest slot on a tie
	always_comb begin
		sq        = {1'b0, sqx_s1} + {1'b0, sqy_s1};
		better    = vld_s1 && (CMP_W'(sq) < CMP_W'(best_sq_q));
		best_sq_d = better ? BSQ_W'(sq) : best_sq_q;
		best_d    = better ? idx_s1 : best_q;
		found_d   = better | found_q;
	end

	// Square root: two result bits per cycle
	always_comb begin
		r1    = {rem_q, rad_q[RAD_W-1 -: 2]};
		t1    = (REM_W+2)'({root_q, 2'b01});
		ge1   = r1 >= t1;
		rem1  = ge1 ? REM_W'(r1 - t1) : REM_W'(r1);
		root1 = {root_q[R_PAD-2:0], ge1};
		r2    = {rem1, rad_q[RAD_W-3 -: 2]};
		t2    = (REM_W+2)'({root1, 2'b01});
		ge2   = r2 >= t2;
		rem2  = ge2 ? REM_W'(r2 - t2) : REM_W'(r2);
		root2 = {root1[R_PAD-2:0], ge2};
	end

	// Round to nearest: step up when the remainder exceeds the root
	always_comb begin
		rounded   = {1'b0, root_q} + (R_PAD+1)'(rem_q > {2'b00, root_q});
		near_dist = found_q ? D_W'(rounded) : FAR_DIST;
		stat.done = (state_q == qcrt_pkg::LANE_DONE);
		stat.slot = best_q;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			qcrt_pkg::LANE_IDLE: begin
				if (start) state_d = qcrt_pkg::LANE_DIST;
			end
			qcrt_pkg::LANE_DIST: begin
				if (j_q == SLOT_W'(qcrt_pkg::NUM_CORNERS - 1)) state_d = qcrt_pkg::LANE_CMP;
			end
			qcrt_pkg::LANE_CMP: begin
				state_d = qcrt_pkg::LANE_ROOT;
			end
			qcrt_pkg::LANE_ROOT: begin
				if (step_q == STEP_W'(STEPS - 1)) state_d = qcrt_pkg::LANE_DONE;
			end
			qcrt_pkg::LANE_DONE: begin
				if (clear) state_d = qcrt_pkg::LANE_IDLE;
			end
			default: begin
				state_d = qcrt_pkg::LANE_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= qcrt_pkg::LANE_IDLE;
			vld_s1  <= 1'b0;
			j_q     <= '0;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			vld_s1  <= (state_q == qcrt_pkg::LANE_DIST);
			if (state_q == qcrt_pkg::LANE_IDLE) j_q <= '0;
			else if (state_q == qcrt_pkg::LANE_DIST) j_q <= j_q + 1'b1;
			if (state_q == qcrt_pkg::LANE_CMP) step_q <= '0;
			else if (state_q == qcrt_pkg::LANE_ROOT) step_q <= step_q + 1'b1;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		sqx_s1 <= dx * dx;
		sqy_s1 <= dy * dy;
		idx_s1 <= j_q;
		if (state_q == qcrt_pkg::LANE_IDLE) begin
			best_sq_q <= BOUND_SQ;
			best_q    <= '0;
			found_q   <= 1'b0;
		end else if (state_q == qcrt_pkg::LANE_DIST || state_q == qcrt_pkg::LANE_CMP) begin
			best_sq_q <= best_sq_d;
			best_q    <= best_d;
			found_q   <= found_d;
		end
		if (state_q == qcrt_pkg::LANE_CMP) begin
			rad_q  <= RAD_W'(best_sq_d) << (2 * FRACTION_BITS);
			rem_q  <= '0;
			root_q <= '0;
		end else if (state_q == qcrt_pkg::LANE_ROOT) begin
			rad_q  <= rad_q << 4;
			rem_q  <= rem2;
			root_q <= root2;
		end
	end

endmodule

// File: src/qcrt_merge.sv
// Merge stage: slot placement, distance sum, limit test and stored quad.
module qcrt_merge #(
	parameter int COORD_BITS    = qcrt_pkg::COORD_BITS_DEF,
	parameter int FRACTION_BITS = qcrt_pkg::FRACTION_BITS_DEF,
	localparam int D_W          = qcrt_pkg::BOUND_W + FRACTION_BITS,
	localparam int NC           = qcrt_pkg::NUM_CORNERS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 fire,
	input  logic                                 stored,
	input  logic [qcrt_pkg::LIMIT_BITS-1:0]      limit,
	input  logic [NC-1:0][COORD_BITS-1:0]        nx,
	input  logic [NC-1:0][COORD_BITS-1:0]        ny,
	input  qcrt_pkg::lane_stat_t [NC-1:0]        stat,
	input  logic [NC-1:0][D_W-1:0]               near_dist,
	output logic [NC-1:0][COORD_BITS-1:0]        qx,
	output logic [NC-1:0][COORD_BITS-1:0]        qy,
	output logic                                 reordered
);

	localparam int SUM_W = D_W + 2;

	logic [NC-1:0][COORD_BITS-1:0] rx, ry;
	logic [SUM_W-1:0]              sum, thr;
	logic                          accept;

	// Later corners overwrite earlier ones in a shared slot; unpicked slots stay zero
	always_comb begin
		rx  = '0;
		ry  = '0;
		sum = '0;
		for (int i = 0; i < NC; i++) begin
			rx[stat[i].slot] = nx[i];
			ry[stat[i].slot] = ny[i];
			sum = sum + SUM_W'(near_dist[i]);
		end
		thr    = SUM_W'(limit) << FRACTION_BITS;
		accept = stored && (sum < thr);
	end

	// Output quad doubles as the stored previous quad
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qx        <= '0;
			qy        <= '0;
			reordered <= 1'b0;
		end else if (fire) begin
			qx        <= accept ? rx : nx;
			qy        <= accept ? ry : ny;
			reordered <= accept;
		end
	end

endmodule

// File: src/quad_corner_reorder_tracker.sv
// Quad corner reorder tracker. Each request carries four corner points; the block
// keeps the last output quad and, once one is stored, moves every new corner to the
// slot of its nearest stored corner (ties to the lowest slot, a later corner
// overwriting an earlier one, unpicked slots at zero). Four lanes, one per new
// corner, scan the stored corners one a cycle and take a rounded square root two
// bits a cycle; the merge stage sums the four distances and keeps the new
// arrangement when the sum is below match_limit. One request is worked on at a
// time; the next is accepted once the last has passed to the output register;
// the lane square root, over a root width of R = 2*ceil((27 + 2*FRACTION_BITS)/4)
// bits, 18 at FRACTION_BITS = 4, takes most of the working time. The output register
// holds a finished result while the next request is already being worked on.
`include "quad_corner_reorder_tracker_defines.svh"

module quad_corner_reorder_tracker #(
	parameter int COORD_BITS    = qcrt_pkg::COORD_BITS_DEF,
	parameter int FRACTION_BITS = qcrt_pkg::FRACTION_BITS_DEF,
	localparam int NC           = qcrt_pkg::NUM_CORNERS,
	localparam int TD_W         = ((2 * NC * COORD_BITS + 7) / 8) * 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// corner_a_x, corner_a_y, corner_b_x, corner_b_y, corner_c_x, corner_c_y,
	// corner_d_x, corner_d_y
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [TD_W-1:0]                    s_axis_tdata,
	// slot_a_x, slot_a_y, slot_b_x, slot_b_y, slot_c_x, slot_c_y, slot_d_x, slot_d_y
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [TD_W-1:0]                    m_axis_tdata,
	// was_reordered
	output logic                               m_axis_tuser,
	input  logic                               cfg_wr_en,
	input  logic [qcrt_pkg::LIMIT_BITS-1:0]    cfg_wr_data
);

	localparam int D_W = qcrt_pkg::BOUND_W + FRACTION_BITS;

	logic [qcrt_pkg::LIMIT_BITS-1:0]     match_limit_q;
	logic                                busy_q, stored_q, m_valid_q;
	logic [2*NC-1:0][COORD_BITS-1:0]     in_q;
	logic [2*NC-1:0][COORD_BITS-1:0]     out_fields;
	logic [NC-1:0][COORD_BITS-1:0]       nx, ny, qx, qy;
	qcrt_pkg::lane_stat_t [NC-1:0]       stat;
	logic [NC-1:0][D_W-1:0]              near_dist;
	logic [NC-1:0]                       lane_done;
	logic                                in_acc, fire, reordered;

	assign s_axis_tready = !busy_q;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign fire          = busy_q && (&lane_done) && (!m_valid_q || m_axis_tready);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = reordered;

	// Unpack corners and pack slots, x in the lower field of each pair
	always_comb begin
		for (int i = 0; i < NC; i++) begin
			nx[i]               = in_q[2*i];
			ny[i]               = in_q[2*i+1];
			out_fields[2*i]     = qx[i];
			out_fields[2*i+1]   = qy[i];
			lane_done[i]        = stat[i].done;
		end
		m_axis_tdata = TD_W'(out_fields);
	end

	// Request capture
	always_ff @(posedge clk) begin
		if (in_acc) in_q <= (2*NC*COORD_BITS)'(s_axis_tdata);
	end

	// Control and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_limit_q <= qcrt_pkg::LIMIT_RESET;
			busy_q        <= 1'b0;
			stored_q      <= 1'b0;
			m_valid_q     <= 1'b0;
		end else begin
			if (cfg_wr_en) match_limit_q <= cfg_wr_data;
			if (in_acc) busy_q <= 1'b1;
			else if (fire) busy_q <= 1'b0;
			if (fire) stored_q <= 1'b1;
			if (fire) m_valid_q <= 1'b1;
			else if (m_axis_tready) m_valid_q <= 1'b0;
		end
	end

	// One lane per new corner
	for (genvar g = 0; g < NC; g++) begin : g_lane
		qcrt_lane #(
			.COORD_BITS    (COORD_BITS),
			.FRACTION_BITS (FRACTION_BITS)
		) u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.start     (in_acc),
			.clear     (fire),
			.nx        (nx[g]),
			.ny        (ny[g]),
			.px        (qx),
			.py        (qy),
			.stat      (stat[g]),
			.near_dist (near_dist[g])
		);
	end

	qcrt_merge #(
		.COORD_BITS    (COORD_BITS),
		.FRACTION_BITS (FRACTION_BITS)
	) u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.stored    (stored_q),
		.limit     (match_limit_q),
		.nx        (nx),
		.ny        (ny),
		.stat      (stat),
		.near_dist (near_dist),
		.qx        (qx),
		.qy        (qy),
		.reordered (reordered)
	);

	// Lanes run in lock step and are idle between requests
	`QCRT_ASSERT(a_lanes_together, lane_done[0] |-> (&lane_done))
	`QCRT_NEVER(a_done_when_idle, !busy_q && (lane_done != '0))
	`QCRT_ASSERT(a_first_passthrough, fire && !stored_q |=> m_axis_tuser == 1'b0)

endmodule

// File: test/quad_corner_reorder_tracker_tb.sv
// Self-checking testbench for the quad corner reorder tracker.
`timescale 1ns / 1ps

module quad_corner_reorder_tracker_tb;

	localparam int COORD_W = qcrt_pkg::COORD_BITS_DEF;
	localparam int FRAC_W  = qcrt_pkg::FRACTION_BITS_DEF;
	localparam int NC      = qcrt_pkg::NUM_CORNERS;
	localparam int TD_W    = ((2 * NC * COORD_W + 7) / 8) * 8;
	localparam int LIM_W   = qcrt_pkg::LIMIT_BITS;

	typedef logic [COORD_W-1:0] coord_t;

	typedef struct {
		coord_t x[NC];
		coord_t y[NC];
	} quad_t;

	typedef struct {
		quad_t quad;
		bit    reord;
	} slot_result_t;

	// Packing shared by requests and results: x then y per corner, corner a lowest
	function automatic logic [TD_W-1:0] pack_quad(quad_t q);
		logic [TD_W-1:0] d;
		d = '0;
		for (int i = 0; i < NC; i++) begin
			d[2*i*COORD_W +: COORD_W]     = q.x[i];
			d[(2*i+1)*COORD_W +: COORD_W] = q.y[i];
		end
		return d;
	endfunction

	function automatic quad_t unpack_quad(logic [TD_W-1:0] d);
		quad_t q;
		for (int i = 0; i < NC; i++) begin
			q.x[i] = d[2*i*COORD_W +: COORD_W];
			q.y[i] = d[(2*i+1)*COORD_W +: COORD_W];
		end
		return q;
	endfunction

	// Tracks the stored quad and the limit, and holds expected slot arrangements
	class quad_track_board;
		quad_t          last_quad;
		bit             quad_held;
		longint unsigned limit;
		int             failures;
		slot_result_t   pending_quads[$];

		function new();
			for (int i = 0; i < NC; i++) begin
				last_quad.x[i] = '0;
				last_quad.y[i] = '0;
			end
			quad_held = 0;
			limit     = 64'(qcrt_pkg::LIMIT_RESET);
			failures  = 0;
		endfunction

		function void set_limit(logic [LIM_W-1:0] v);
			limit = 64'(v);
		endfunction

		function int pending();
			return pending_quads.size();
		endfunction

		// Integer square root by bisection
		function longint unsigned floor_root(longint unsigned v);
			longint unsigned lo;
			longint unsigned hi;
			longint unsigned mid;
			lo = 0;
			hi = 64'd1 << 24;
			while (hi - lo > 1) begin
				mid = (lo + hi) >> 1;
				if (mid * mid <= v)
					lo = mid;
				else
					hi = mid;
			end
			return lo;
		endfunction

		// Distance with FRAC_W fraction bits, rounded to nearest
		function longint unsigned root_rounded(longint unsigned sq);
			longint unsigned v;
			longint unsigned s;
			v = sq << (2 * FRAC_W);
			s = floor_root(v);
			if (v - s * s > s)
				s++;
			return s;
		endfunction

		function void note_request(quad_t q);
			slot_result_t    res;
			quad_t           moved;
			longint unsigned sum;
			longint unsigned sq;
			longint unsigned best_sq;
			longint unsigned dx;
			longint unsigned dy;
			int              best;
			bit              found;
			res.quad  = q;
			res.reord = 0;
			for (int i = 0; i < NC; i++) begin
				moved.x[i] = '0;
				moved.y[i] = '0;
			end
			if (quad_held) begin
				sum = 0;
				for (int i = 0; i < NC; i++) begin
					best    = 0;
					best_sq = longint'(qcrt_pkg::BOUND_DIST) * qcrt_pkg::BOUND_DIST;
					found   = 0;
					for (int j = 0; j < NC; j++) begin
						dx = (last_quad.x[j] > q.x[i]) ? 64'(last_quad.x[j] - q.x[i])
							: 64'(q.x[i] - last_quad.x[j]);
						dy = (last_quad.y[j] > q.y[i]) ? 64'(last_quad.y[j] - q.y[i])
							: 64'(q.y[i] - last_quad.y[j]);
						sq = dx * dx + dy * dy;
						// strict compare keeps the lowest slot on a tie
						if (sq < best_sq) begin
							best_sq = sq;
							best    = j;
							found   = 1;
						end
					end
					// a later corner overwrites an earlier one in the same slot
					moved.x[best] = q.x[i];
					moved.y[best] = q.y[i];
					if (found)
						sum += root_rounded(best_sq);
					else
						sum += longint'(qcrt_pkg::BOUND_DIST) << FRAC_W;
				end
				if (sum < (limit << FRAC_W)) begin
					res.quad  = moved;
					res.reord = 1;
				end
			end
			last_quad = res.quad;
			quad_held = 1;
			pending_quads = {pending_quads, res};
		endfunction

		function void check_result(logic [TD_W-1:0] data, logic reord_bit);
			slot_result_t exp_res;
			quad_t        got;
			string        slot_tag;
			if (pending_quads.size() == 0) begin
				$error("unexpected result, no request outstanding: tdata=%h", data);
				failures++;
				return;
			end
			exp_res = pending_quads.pop_front();
			got     = unpack_quad(data);
			for (int i = 0; i < NC; i++) begin
				slot_tag = $sformatf("slot_%c", 8'h61 + i);
				if (got.x[i] !== exp_res.quad.x[i]) begin
					$error("%s_x: expected %0d, got %0d", slot_tag, exp_res.quad.x[i],
						got.x[i]);
					failures++;
				end
				if (got.y[i] !== exp_res.quad.y[i]) begin
					$error("%s_y: expected %0d, got %0d", slot_tag, exp_res.quad.y[i],
						got.y[i]);
					failures++;
				end
			end
			if (reord_bit !== exp_res.reord) begin
				$error("was_reordered: expected %0d, got %0d", exp_res.reord, reord_bit);
				failures++;
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [TD_W-1:0]       s_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [TD_W-1:0]       m_axis_tdata;
	logic                  m_axis_tuser;
	logic                  cfg_wr_en;
	logic [LIM_W-1:0]      cfg_wr_data;

	quad_track_board board;
	int              burst_left;
	bit              hold_off_req;

	quad_corner_reorder_tracker dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Hard stop well beyond the slowest legal run
	initial begin
		#10_000_000;
		$display("quad_corner_reorder_tracker_tb: FAIL");
		$finish;
	end

	function automatic quad_t make_quad(int ax, int ay, int bx, int by,
			int cx, int cy, int dx, int dy);
		quad_t q;
		q.x[0] = coord_t'(ax); q.y[0] = coord_t'(ay);
		q.x[1] = coord_t'(bx); q.y[1] = coord_t'(by);
		q.x[2] = coord_t'(cx); q.y[2] = coord_t'(cy);
		q.x[3] = coord_t'(dx); q.y[3] = coord_t'(dy);
		return q;
	endfunction

	function automatic quad_t random_quad();
		quad_t q;
		for (int i = 0; i < NC; i++) begin
			q.x[i] = coord_t'($urandom);
			q.y[i] = coord_t'($urandom);
		end
		return q;
	endfunction

	// Moves each corner a little and shuffles the corner order
	function automatic quad_t nudge_quad(quad_t base, int spread);
		quad_t  q;
		int     v;
		int     k;
		coord_t tx;
		coord_t ty;
		for (int i = 0; i < NC; i++) begin
			v = int'(base.x[i]) + int'($urandom_range(0, 2 * spread)) - spread;
			q.x[i] = coord_t'((v < 0) ? 0 : (v > 4095) ? 4095 : v);
			v = int'(base.y[i]) + int'($urandom_range(0, 2 * spread)) - spread;
			q.y[i] = coord_t'((v < 0) ? 0 : (v > 4095) ? 4095 : v);
		end
		for (int i = NC - 1; i > 0; i--) begin
			k = $urandom_range(0, i);
			tx = q.x[i]; ty = q.y[i];
			q.x[i] = q.x[k]; q.y[i] = q.y[k];
			q.x[k] = tx; q.y[k] = ty;
		end
		return q;
	endfunction

	// Offer one request, wait for acceptance, then maybe pause between bursts
	task automatic push_quad(quad_t q);
		int gap;
		s_axis_tdata  <= pack_quad(q);
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		board.note_request(q);
		@(negedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60)
				: $urandom_range(0, 10);
		end
	endtask

	// Stop offering and let every outstanding result drain
	task automatic drain_all();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (board.pending() != 0) @(negedge clk);
	endtask

	task automatic write_limit(logic [LIM_W-1:0] v);
		drain_all();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		board.set_limit(v);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	// Receiver: changing ready pattern, with a long hold-off on demand
	initial begin
		int          mode;
		int          cyc;
		logic [15:0] pat;
		m_axis_tready = 1'b0;
		mode = 0;
		cyc  = 0;
		pat  = 16'b1100_1010_0111_0001;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 0;
				m_axis_tready <= 1'b0;
				repeat (300) @(negedge clk);
			end else begin
				cyc++;
				if (cyc % 64 == 0)
					mode = $urandom_range(0, 3);
				pat = {pat[14:0], pat[15]};
				case (mode)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= 1'($urandom_range(0, 1));
					2: m_axis_tready <= ($urandom_range(0, 4) == 0);
					default: m_axis_tready <= pat[0];
				endcase
			end
		end
	end

	// Result monitor
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			board.check_result(m_axis_tdata, m_axis_tuser);
	end

	// Main stimulus
	initial begin
		quad_t            q;
		quad_t            corner_box;
		logic [LIM_W-1:0] phase_limit;
		int               pick;
		board         = new();
		burst_left    = 0;
		hold_off_req  = 0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		cfg_wr_en     = 1'b0;
		cfg_wr_data   = '0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: pass-through with nothing stored, then exact and shuffled repeats
		q = make_quad(100, 200, 300, 200, 300, 400, 100, 400);
		push_quad(q);
		push_quad(q);
		push_quad(make_quad(302, 401, 101, 199, 99, 402, 299, 201));
		// far jumps to the field extremes
		push_quad(make_quad(4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095));
		push_quad(make_quad(0, 0, 0, 0, 0, 0, 0, 0));
		// stored corners all equal: ties to slot a, overwrites, empty slots
		push_quad(make_quad(1, 0, 0, 1, 2, 0, 0, 2));
		corner_box = make_quad(4095, 0, 0, 4095, 4095, 4095, 0, 0);
		push_quad(corner_box);
		push_quad(make_quad(0, 0, 4095, 4095, 0, 4095, 4095, 0));
		// limit zero: never reordered
		write_limit('0);
		push_quad(make_quad(0, 0, 4095, 4095, 0, 4095, 4095, 0));
		push_quad(corner_box);
		// largest limit: any stored quad matches
		write_limit('1);
		push_quad(random_quad());
		push_quad(random_quad());
		push_quad(nudge_quad(board.last_quad, 3));

		// Random phases, each under its own limit
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: phase_limit = qcrt_pkg::LIMIT_RESET;
				1: phase_limit = LIM_W'($urandom_range(20, 400));
				2: phase_limit = '1;
				3: phase_limit = LIM_W'($urandom);
				4: phase_limit = 16'd60;
				default: phase_limit = '0;
			endcase
			write_limit(phase_limit);
			for (int n = 0; n < 250; n++) begin
				if ((phase == 0 || phase == 4) && n == 60)
					hold_off_req = 1;
				pick = $urandom_range(0, 9);
				if (pick < 5) begin
					q = nudge_quad(board.last_quad, $urandom_range(0, 4));
				end else if (pick < 7) begin
					q = nudge_quad(board.last_quad, $urandom_range(5, 40));
				end else if (pick == 7) begin
					// duplicate corners provoke shared slots and ties later on
					q = nudge_quad(board.last_quad, $urandom_range(0, 3));
					q.x[1] = q.x[0];
					q.y[1] = q.y[0];
				end else begin
					q = random_quad();
				end
				push_quad(q);
			end
		end

		drain_all();
		repeat (20) @(posedge clk);
		if (board.failures == 0 && board.pending() == 0) begin
			$display("quad_corner_reorder_tracker_tb: PASS");
		end else begin
			$display("quad_corner_reorder_tracker_tb: FAIL");
		end
		$finish;
	end

endmodule
